FILE: design/vbs_pkg.sv
// shared types and constants for the variance block switch
// frame geometry, field widths, block kinds, register indexes and stage records
// no dependencies
`timescale 1ns / 1ps

package vbs_pkg;

    // frame geometry, segment length must be a power of two
    localparam int FRAME_LEN = 2048;
    localparam int SEGMENTS  = 2;
    localparam int SEG_LEN   = FRAME_LEN / SEGMENTS;
    localparam int USED_LEN  = SEG_LEN * SEGMENTS;
    localparam int SEG_SHIFT = $clog2(SEG_LEN);
    localparam int CNT_W     = $clog2(FRAME_LEN);

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W;
    localparam int SQR_W    = 2 * MAG_W - 1;
    localparam int SUM_W    = MAG_W + SEG_SHIFT;
    localparam int SQ_W     = SQR_W + SEG_SHIFT;
    localparam int NUM_W    = SQ_W + SEG_SHIFT;
    localparam int VAR_W    = 29;
    localparam int QUOT_W   = NUM_W - 2 * SEG_SHIFT;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    // largest possible segment variance, 1.0 / 4 in q0.30
    localparam logic [QUOT_W-1:0] VAR_MAX = QUOT_W'(1 << 28);

    // register reset values, q0.30
    localparam logic [VAR_W-1:0] ENERGY_FLOOR_RST     = 29'd80530637;
    localparam logic [VAR_W-1:0] RISE_AFTER_LONG_RST  = 29'd32212255;
    localparam logic [VAR_W-1:0] RISE_AFTER_SHORT_RST = 29'd3221225;

    typedef enum logic [KIND_W-1:0] {
        KIND_ONLY_LONG  = 2'd0,
        KIND_LONG_START = 2'd1,
        KIND_ONLY_SHORT = 2'd2,
        KIND_LONG_STOP  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_FLOOR     = 2'd0,
        CFG_RISE_AFTER_LONG  = 2'd1,
        CFG_RISE_AFTER_SHORT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [VAR_W-1:0] energy_floor;
        logic [VAR_W-1:0] rise_after_long;
        logic [VAR_W-1:0] rise_after_short;
    } cfg_t;

    // closed segment and/or frame end from the accumulator
    typedef struct packed {
        logic             valid;
        logic             seg_end;
        logic             frame_end;
        logic [SUM_W-1:0] s1;
        logic [SQ_W-1:0]  s2;
    } seg_evt_t;

    // finished frame peak for the decision stage
    typedef struct packed {
        logic             valid;
        logic [VAR_W-1:0] peak;
    } peak_evt_t;

endpackage

FILE: design/variance_block_switch_unit.sv
// top level of the variance block switch
// holds the threshold registers and connects vbs_accum, vbs_variance, vbs_decide
// uses vbs_pkg
`timescale 1ns / 1ps

// usage
//   sample channel: one signed 16-bit pcm sample per request (sample_valid /
//   sample_ready). frames are 2048 samples, cut into two segments of 1024.
//   result channel: one request per frame (result_valid / result_ready) with
//   block_kind, short_coding, peak_variance and variance_change.
//   config channel: cfg_index selects energy_floor (0), rise_after_long (1)
//   or rise_after_short (2); cfg_data is the q0.30 value. always ready.
//   index 3 is taken and ignored. write only while no frame is in flight.
// throughput: one sample per cycle. the last sample of a frame is held off
//   only while the previous frame's result has not been taken yet.
// result path: the last sample of a frame passes the accumulate, square,
//   variance/peak and decision registers before result_valid rises.
// reset: all sums, the frame position and the frame peak clear, the previous
//   peak reads zero, the previous block kind is only long, and the thresholds
//   return to 0.075, 0.03 and 0.003.
// receiver stall: the result stays in its register; samples keep flowing
//   until the next frame's last sample, which waits for the result to leave.
module variance_block_switch_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [vbs_pkg::SAMPLE_W-1:0]   sample,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [vbs_pkg::KIND_W-1:0]            block_kind,
    output logic                                  short_coding,
    output logic [vbs_pkg::VAR_W-1:0]             peak_variance,
    output logic [vbs_pkg::VAR_W-1:0]             variance_change,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vbs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vbs_pkg::VAR_W-1:0]             cfg_data
);

    // threshold registers
    logic [vbs_pkg::VAR_W-1:0] energy_floor_reg;
    logic [vbs_pkg::VAR_W-1:0] rise_after_long_reg;
    logic [vbs_pkg::VAR_W-1:0] rise_after_short_reg;
    vbs_pkg::cfg_t             cfg;

    // stage records
    vbs_pkg::seg_evt_t         seg_evt;
    vbs_pkg::peak_evt_t        peak_evt;
    logic                      result_taken;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_floor_reg     <= vbs_pkg::ENERGY_FLOOR_RST;
            rise_after_long_reg  <= vbs_pkg::RISE_AFTER_LONG_RST;
            rise_after_short_reg <= vbs_pkg::RISE_AFTER_SHORT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vbs_pkg::cfg_idx_t'(cfg_index))
                vbs_pkg::CFG_ENERGY_FLOOR:
                begin
                    energy_floor_reg <= cfg_data;
                end
                vbs_pkg::CFG_RISE_AFTER_LONG:
                begin
                    rise_after_long_reg <= cfg_data;
                end
                vbs_pkg::CFG_RISE_AFTER_SHORT:
                begin
                    rise_after_short_reg <= cfg_data;
                end
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign cfg.energy_floor     = energy_floor_reg;
    assign cfg.rise_after_long  = rise_after_long_reg;
    assign cfg.rise_after_short = rise_after_short_reg;

    // releases the hold on the next frame's last sample
    assign result_taken = result_valid && result_ready;

    // magnitude, sums, frame position
    vbs_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_taken (result_taken),
        .seg_evt      (seg_evt)
    );

    // segment variance, frame maximum
    vbs_variance u_variance (
        .clk      (clk),
        .rst_n    (rst_n),
        .seg_evt  (seg_evt),
        .peak_evt (peak_evt)
    );

    // decision, sequencer, result register
    vbs_decide u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .peak_evt        (peak_evt),
        .cfg             (cfg),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .block_kind      (block_kind),
        .short_coding    (short_coding),
        .peak_variance   (peak_variance),
        .variance_change (variance_change)
    );

endmodule

FILE: design/vbs_accum.sv
// input stage: magnitude, per-segment sum and sum of squares, frame position
// emits a segment record at each segment end and frame end; uses vbs_pkg
`timescale 1ns / 1ps

module vbs_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [vbs_pkg::SAMPLE_W-1:0] sample,
    input  logic                                result_taken,
    output vbs_pkg::seg_evt_t                   seg_evt
);

    logic [vbs_pkg::CNT_W-1:0] count_reg;
    logic [vbs_pkg::SUM_W-1:0] s1_reg;
    logic [vbs_pkg::SQ_W-1:0]  s2_reg;
    logic                      pending_reg;

    logic                      evt_valid_reg;
    logic                      evt_seg_reg;
    logic                      evt_frame_reg;
    logic [vbs_pkg::SUM_W-1:0] evt_s1_reg;
    logic [vbs_pkg::SQ_W-1:0]  evt_s2_reg;

    logic [vbs_pkg::MAG_W-1:0] mag;
    logic [2*vbs_pkg::MAG_W-1:0] sqr_full;
    logic [vbs_pkg::SUM_W-1:0] s1_next;
    logic [vbs_pkg::SQ_W-1:0]  s2_next;
    logic                      accept;
    logic                      last_sample;
    logic                      in_seg;
    logic                      seg_last;

    // -32768 maps to 32768, which still fits unsigned 16 bits
    assign mag      = sample[vbs_pkg::SAMPLE_W-1] ? vbs_pkg::MAG_W'(-sample)
                                                   : vbs_pkg::MAG_W'(sample);
    assign sqr_full = mag * mag;
    assign s1_next  = s1_reg + vbs_pkg::SUM_W'(mag);
    assign s2_next  = s2_reg + vbs_pkg::SQ_W'(sqr_full[vbs_pkg::SQR_W-1:0]);

    assign last_sample = (count_reg == vbs_pkg::CNT_W'(vbs_pkg::FRAME_LEN - 1));
    assign in_seg      = (32'(count_reg) < vbs_pkg::USED_LEN);
    assign seg_last    = in_seg && (&count_reg[vbs_pkg::SEG_SHIFT-1:0]);

    // the last sample of a frame waits until the previous result is gone
    assign sample_ready = !(last_sample && pending_reg);
    assign accept       = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            pending_reg   <= 1'b0;
            evt_valid_reg <= 1'b0;
            evt_seg_reg   <= 1'b0;
            evt_frame_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= accept && (seg_last || last_sample);
            evt_seg_reg   <= seg_last;
            evt_frame_reg <= last_sample;
            if (accept)
            begin
                if (seg_last || last_sample)
                begin
                    s1_reg <= '0;
                    s2_reg <= '0;
                end
                else if (in_seg)
                begin
                    s1_reg <= s1_next;
                    s2_reg <= s2_next;
                end
                if (last_sample)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (accept && last_sample)
            begin
                pending_reg <= 1'b1;
            end
            else if (result_taken)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && seg_last)
        begin
            evt_s1_reg <= s1_next;
            evt_s2_reg <= s2_next;
        end
    end

    assign seg_evt.valid     = evt_valid_reg;
    assign seg_evt.seg_end   = evt_seg_reg;
    assign seg_evt.frame_end = evt_frame_reg;
    assign seg_evt.s1        = evt_s1_reg;
    assign seg_evt.s2        = evt_s2_reg;

`ifndef SYNTHESIS
    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) < vbs_pkg::FRAME_LEN)
        else $error("frame position out of range");

    a_frame_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && evt_frame_reg |-> count_reg == '0 && !evt_valid_reg == 1'b0)
        else $error("frame end without counter restart");

    a_pending_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && evt_frame_reg |-> pending_reg)
        else $error("frame end reached decision path without pending mark");
`endif

endmodule

FILE: design/vbs_variance.sv
// segment variance and running frame peak
// square of the magnitude sum, then exact variance and maximum; uses vbs_pkg
`timescale 1ns / 1ps

module vbs_variance (
    input  logic               clk,
    input  logic               rst_n,
    input  vbs_pkg::seg_evt_t  seg_evt,
    output vbs_pkg::peak_evt_t peak_evt
);

    // square stage
    logic                        b_valid_reg;
    logic                        b_seg_reg;
    logic                        b_frame_reg;
    logic [vbs_pkg::NUM_W-1:0]   b_sq_reg;
    logic [vbs_pkg::NUM_W-1:0]   b_s2_reg;
    logic [2*vbs_pkg::SUM_W-1:0] prod;

    // variance and peak stage
    logic [vbs_pkg::VAR_W-1:0]   frame_peak_reg;
    logic                        peak_valid_reg;
    logic [vbs_pkg::VAR_W-1:0]   peak_out_reg;
    logic [vbs_pkg::NUM_W-1:0]   num;
    logic [vbs_pkg::QUOT_W-1:0]  var_full;
    logic [vbs_pkg::VAR_W-1:0]   seg_var;
    logic [vbs_pkg::VAR_W-1:0]   peak_cand;

    assign prod = seg_evt.s1 * seg_evt.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_seg_reg   <= 1'b0;
            b_frame_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= seg_evt.valid;
            b_seg_reg   <= seg_evt.seg_end;
            b_frame_reg <= seg_evt.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_evt.valid && seg_evt.seg_end)
        begin
            b_sq_reg <= prod[vbs_pkg::NUM_W-1:0];
            b_s2_reg <= {seg_evt.s2, {vbs_pkg::SEG_SHIFT{1'b0}}};
        end
    end

    // (L*S2 - S1^2) / L^2, L a power of two
    assign num       = b_s2_reg - b_sq_reg;
    assign var_full  = num[vbs_pkg::NUM_W-1:2*vbs_pkg::SEG_SHIFT];
    assign seg_var   = var_full[vbs_pkg::VAR_W-1:0];
    assign peak_cand = (b_seg_reg && (seg_var > frame_peak_reg)) ? seg_var : frame_peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_peak_reg <= '0;
            peak_valid_reg <= 1'b0;
        end
        else
        begin
            peak_valid_reg <= b_valid_reg && b_frame_reg;
            if (b_valid_reg)
            begin
                frame_peak_reg <= b_frame_reg ? '0 : peak_cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && b_frame_reg)
        begin
            peak_out_reg <= peak_cand;
        end
    end

    assign peak_evt.valid = peak_valid_reg;
    assign peak_evt.peak  = peak_out_reg;

`ifndef SYNTHESIS
    a_var_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_seg_reg |-> var_full <= vbs_pkg::VAR_MAX)
        else $error("segment variance exceeds one quarter");

    a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_frame_reg |=> frame_peak_reg == '0)
        else $error("frame peak not cleared at frame end");

    a_peak_single: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid_reg |=> !peak_valid_reg)
        else $error("frame peak issued on two cycles in a row");
`endif

endmodule

FILE: design/vbs_decide.sv
// coding decision, window sequencer and result register
// compares the frame peak and its change against the thresholds; uses vbs_pkg
`timescale 1ns / 1ps

module vbs_decide (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vbs_pkg::peak_evt_t               peak_evt,
    input  vbs_pkg::cfg_t                    cfg,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [vbs_pkg::KIND_W-1:0]       block_kind,
    output logic                             short_coding,
    output logic [vbs_pkg::VAR_W-1:0]        peak_variance,
    output logic [vbs_pkg::VAR_W-1:0]        variance_change
);

    vbs_pkg::kind_t            last_kind_reg;
    vbs_pkg::kind_t            kind_next;
    logic [vbs_pkg::VAR_W-1:0] last_peak_reg;

    logic                      result_valid_reg;
    vbs_pkg::kind_t            kind_reg;
    logic                      short_reg;
    logic [vbs_pkg::VAR_W-1:0] peak_reg;
    logic [vbs_pkg::VAR_W-1:0] change_reg;

    logic [vbs_pkg::VAR_W-1:0] change;
    logic [vbs_pkg::VAR_W-1:0] threshold;
    logic                      go_short;

    // coding decision
    always_comb
    begin
        change    = (peak_evt.peak >= last_peak_reg) ? (peak_evt.peak - last_peak_reg)
                                                     : (last_peak_reg - peak_evt.peak);
        threshold = (last_kind_reg == vbs_pkg::KIND_ONLY_SHORT) ? cfg.rise_after_short
                                                                : cfg.rise_after_long;
        go_short  = (peak_evt.peak >= cfg.energy_floor) && (change > threshold);
    end

    // window sequencer: a start window is always followed by short windows
    always_comb
    begin
        unique case (last_kind_reg)
            vbs_pkg::KIND_ONLY_LONG,
            vbs_pkg::KIND_LONG_STOP:
            begin
                kind_next = go_short ? vbs_pkg::KIND_LONG_START : vbs_pkg::KIND_ONLY_LONG;
            end
            vbs_pkg::KIND_LONG_START:
            begin
                kind_next = vbs_pkg::KIND_ONLY_SHORT;
            end
            vbs_pkg::KIND_ONLY_SHORT:
            begin
                kind_next = go_short ? vbs_pkg::KIND_ONLY_SHORT : vbs_pkg::KIND_LONG_STOP;
            end
            default:
            begin
                kind_next = vbs_pkg::KIND_ONLY_LONG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_kind_reg    <= vbs_pkg::KIND_ONLY_LONG;
            last_peak_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (peak_evt.valid)
            begin
                last_kind_reg    <= kind_next;
                last_peak_reg    <= peak_evt.peak;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (peak_evt.valid)
        begin
            kind_reg   <= kind_next;
            short_reg  <= go_short;
            peak_reg   <= peak_evt.peak;
            change_reg <= change;
        end
    end

    // result outputs
    assign result_valid    = result_valid_reg;
    assign block_kind      = kind_reg;
    assign short_coding    = short_reg;
    assign peak_variance   = peak_reg;
    assign variance_change = change_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        peak_evt.valid |-> !result_valid_reg)
        else $error("new frame result while previous one still held");

    a_short_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && short_reg |->
            kind_reg == vbs_pkg::KIND_LONG_START || kind_reg == vbs_pkg::KIND_ONLY_SHORT)
        else $error("short coding with a long block kind");

    a_start_then_short: assert property (@(posedge clk) disable iff (!rst_n)
        peak_evt.valid && last_kind_reg == vbs_pkg::KIND_LONG_START |=>
            last_kind_reg == vbs_pkg::KIND_ONLY_SHORT)
        else $error("start window not followed by short window");
`endif

endmodule

FILE: sim/vbs_checker.sv
// decision checker for the variance block switch
// watches the sample, result and register write channels, predicts each frame decision
// uses vbs_pkg
`timescale 1ns / 1ps

module vbs_decision_checker (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                sample_valid,
    input  logic                                sample_ready,
    input  logic signed [vbs_pkg::SAMPLE_W-1:0] sample,

    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [vbs_pkg::KIND_W-1:0]          block_kind,
    input  logic                                short_coding,
    input  logic [vbs_pkg::VAR_W-1:0]           peak_variance,
    input  logic [vbs_pkg::VAR_W-1:0]           variance_change,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [vbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vbs_pkg::VAR_W-1:0]           cfg_data,

    output int                                  mismatches,
    output int                                  outstanding
);

    typedef struct packed {
        vbs_pkg::kind_t            kind;
        logic                      short_coding;
        logic [vbs_pkg::VAR_W-1:0] peak;
        logic [vbs_pkg::VAR_W-1:0] change;
    } decision_t;

    decision_t                 decisions_due [$];

    logic [vbs_pkg::VAR_W-1:0] floor_q30;
    logic [vbs_pkg::VAR_W-1:0] rise_long_q30;
    logic [vbs_pkg::VAR_W-1:0] rise_short_q30;

    int                        frame_pos;
    longint unsigned           mag_sum;
    longint unsigned           sq_sum;
    logic [vbs_pkg::VAR_W-1:0] frame_max;
    logic [vbs_pkg::VAR_W-1:0] prior_peak;
    vbs_pkg::kind_t            prior_kind;

    // window sequencer: a start window is always followed by short windows
    function automatic vbs_pkg::kind_t next_window(vbs_pkg::kind_t prev, logic go_short);
        case (prev)
            vbs_pkg::KIND_LONG_START: return vbs_pkg::KIND_ONLY_SHORT;
            vbs_pkg::KIND_ONLY_SHORT:
                return go_short ? vbs_pkg::KIND_ONLY_SHORT : vbs_pkg::KIND_LONG_STOP;
            default:
                return go_short ? vbs_pkg::KIND_LONG_START : vbs_pkg::KIND_ONLY_LONG;
        endcase
    endfunction

    function automatic void check_field(string what, logic [vbs_pkg::VAR_W-1:0] want,
                                        logic [vbs_pkg::VAR_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // accumulate one sample, close segments and the frame
    task automatic absorb_sample(input logic signed [vbs_pkg::SAMPLE_W-1:0] x);
        longint unsigned m;
        longint unsigned seg_n;
        longint unsigned spread;
        decision_t       d;
        seg_n = vbs_pkg::SEG_LEN;
        m = (x < 0) ? -int'(x) : int'(x);
        if (frame_pos < vbs_pkg::USED_LEN) begin
            mag_sum += m;
            sq_sum  += m * m;
            if (frame_pos % vbs_pkg::SEG_LEN == vbs_pkg::SEG_LEN - 1) begin
                spread = (seg_n * sq_sum - mag_sum * mag_sum) / (seg_n * seg_n);
                if (spread > frame_max)
                    frame_max = spread[vbs_pkg::VAR_W-1:0];
                mag_sum = 0;
                sq_sum  = 0;
            end
        end
        if (frame_pos + 1 < vbs_pkg::FRAME_LEN) begin
            frame_pos++;
        end
        else begin
            d.peak   = frame_max;
            d.change = (frame_max >= prior_peak) ? frame_max - prior_peak
                                                 : prior_peak - frame_max;
            if (frame_max < floor_q30)
                d.short_coding = 1'b0;
            else if (prior_kind != vbs_pkg::KIND_ONLY_SHORT)
                d.short_coding = d.change > rise_long_q30;
            else
                d.short_coding = d.change > rise_short_q30;
            d.kind = next_window(prior_kind, d.short_coding);
            decisions_due.push_back(d);
            prior_peak = frame_max;
            prior_kind = d.kind;
            frame_max  = '0;
            frame_pos  = 0;
            mag_sum    = 0;
            sq_sum     = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        decision_t want;
        if (!rst_n) begin
            floor_q30      = vbs_pkg::ENERGY_FLOOR_RST;
            rise_long_q30  = vbs_pkg::RISE_AFTER_LONG_RST;
            rise_short_q30 = vbs_pkg::RISE_AFTER_SHORT_RST;
            frame_pos      = 0;
            mag_sum        = 0;
            sq_sum         = 0;
            frame_max      = '0;
            prior_peak     = '0;
            prior_kind     = vbs_pkg::KIND_ONLY_LONG;
            mismatches     = 0;
            decisions_due.delete();
            outstanding   <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vbs_pkg::CFG_ENERGY_FLOOR:     floor_q30      = cfg_data;
                    vbs_pkg::CFG_RISE_AFTER_LONG:  rise_long_q30  = cfg_data;
                    vbs_pkg::CFG_RISE_AFTER_SHORT: rise_short_q30 = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
                absorb_sample(sample);
            if (result_valid && result_ready) begin
                if (decisions_due.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual kind %0d short %0d",
                             $time, block_kind, short_coding);
                end
                else begin
                    want = decisions_due.pop_front();
                    check_field("block_kind", want.kind, block_kind);
                    check_field("short_coding", want.short_coding, short_coding);
                    check_field("peak_variance", want.peak, peak_variance);
                    check_field("variance_change", want.change, variance_change);
                end
            end
            outstanding <= decisions_due.size();
        end
    end

endmodule

FILE: sim/tb.sv
// testbench top for the variance block switch
// drives frames of pcm samples, threshold writes and result stalls, gives the verdict
// uses vbs_pkg, variance_block_switch_unit and vbs_decision_checker
`timescale 1ns / 1ps

module tb;

    // magnitude of the most negative sample
    localparam int FULL_SCALE = 32768;
    // a segment level reaches full scale, one bit above the sample width
    localparam int LEVEL_W = vbs_pkg::SAMPLE_W + 1;
    // largest variance a segment can reach, 0.25 in q0.30
    localparam logic [vbs_pkg::VAR_W-1:0] Q30_QUARTER  = 29'h1000_0000;
    // top of the register, beyond the variance range
    localparam logic [vbs_pkg::VAR_W-1:0] REG_ALL_ONES = 29'h1FFF_FFFF;
    // register index with no register behind it
    localparam logic [vbs_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // receiver pressure: after this many results, hold off long enough
    // for the next frame to close and the one after to hit its last sample
    localparam int HOLD_AT     = 24;
    localparam int HOLD_CYCLES = 8000;
    // margin after the last result, so the pipe can empty
    localparam int SETTLE_CYCLES = 8;
    // cycles with no request moving on any channel
    localparam int STALL_LIMIT = 40000;

    typedef enum logic [1:0] {
        SEG_STEADY,  // constant magnitude, random sign
        SEG_NOISE,   // magnitude uniform up to the level
        SEG_SPLIT,   // magnitude either zero or the level
        SEG_RAW      // any 16-bit pattern
    } shape_t;

    typedef struct packed {
        shape_t             mode;
        logic [LEVEL_W-1:0] level;
    } seg_shape_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                                sample_valid;
    logic                                sample_ready;
    logic signed [vbs_pkg::SAMPLE_W-1:0] sample;

    logic                                result_valid;
    logic                                result_ready;
    logic [vbs_pkg::KIND_W-1:0]          block_kind;
    logic                                short_coding;
    logic [vbs_pkg::VAR_W-1:0]           peak_variance;
    logic [vbs_pkg::VAR_W-1:0]           variance_change;

    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [vbs_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [vbs_pkg::VAR_W-1:0]           cfg_data;

    int mismatches;
    int outstanding;

    // idle chance in percent per request, changed between phases
    int send_idle_pct;
    int take_idle_pct;

    seg_shape_t                          frame_plan [vbs_pkg::SEGMENTS];
    logic signed [vbs_pkg::SAMPLE_W-1:0] opening [$];

    always #1 clk = ~clk;

    variance_block_switch_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .block_kind      (block_kind),
        .short_coding    (short_coding),
        .peak_variance   (peak_variance),
        .variance_change (variance_change),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    vbs_decision_checker decision_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .block_kind      (block_kind),
        .short_coding    (short_coding),
        .peak_variance   (peak_variance),
        .variance_change (variance_change),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    endfunction

    // one sample following the segment's shape
    function automatic logic signed [vbs_pkg::SAMPLE_W-1:0] draw_sample(seg_shape_t s);
        int m;
        case (s.mode)
            SEG_RAW:    return vbs_pkg::SAMPLE_W'($urandom);
            SEG_STEADY: m = int'(s.level);
            SEG_NOISE:  m = $urandom_range(s.level, 0);
            default:    m = $urandom_range(1, 0) ? int'(s.level) : 0;
        endcase
        // full scale only exists on the negative side
        if (m >= FULL_SCALE || $urandom_range(1, 0))
            return vbs_pkg::SAMPLE_W'(-m);
        return vbs_pkg::SAMPLE_W'(m);
    endfunction

    // sample request: valid held with a stable payload until taken
    task automatic offer_sample(input logic signed [vbs_pkg::SAMPLE_W-1:0] v);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            sample_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // one whole frame; directed opening samples go first if any are queued
    task automatic send_frame();
        seg_shape_t s;
        for (int pos = 0; pos < vbs_pkg::FRAME_LEN; pos++) begin
            s = frame_plan[(pos / vbs_pkg::SEG_LEN < vbs_pkg::SEGMENTS) ?
                           pos / vbs_pkg::SEG_LEN : vbs_pkg::SEGMENTS - 1];
            if (opening.size() != 0)
                offer_sample(opening.pop_front());
            else
                offer_sample(draw_sample(s));
        end
    endtask

    task automatic plan_whole(input shape_t mode, input int level);
        for (int i = 0; i < vbs_pkg::SEGMENTS; i++) begin
            frame_plan[i].mode  = mode;
            frame_plan[i].level = LEVEL_W'(level);
        end
    endtask

    // random frames; half the time the previous plan is kept so the
    // peak barely moves and the long decisions after short ones show up
    task automatic run_frames(input int count);
        repeat (count) begin
            if ($urandom_range(1, 0)) begin
                for (int i = 0; i < vbs_pkg::SEGMENTS; i++) begin
                    frame_plan[i].mode = shape_t'($urandom_range(3, 0));
                    case ($urandom_range(3, 0))
                        0:       frame_plan[i].level = LEVEL_W'(FULL_SCALE);
                        1:       frame_plan[i].level = LEVEL_W'($urandom_range(FULL_SCALE, 0));
                        2:       frame_plan[i].level =
                                     LEVEL_W'($urandom_range(FULL_SCALE, 16000));
                        default: frame_plan[i].level = LEVEL_W'($urandom_range(4000, 0));
                    endcase
                end
            end
            send_frame();
        end
    endtask

    // register write request, valid dropped for a cycle afterwards
    task automatic write_reg(input logic [vbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vbs_pkg::VAR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [vbs_pkg::VAR_W-1:0] floor_v,
                                  input logic [vbs_pkg::VAR_W-1:0] rise_long_v,
                                  input logic [vbs_pkg::VAR_W-1:0] rise_short_v);
        write_reg(vbs_pkg::CFG_ENERGY_FLOOR, floor_v);
        write_reg(vbs_pkg::CFG_RISE_AFTER_LONG, rise_long_v);
        write_reg(vbs_pkg::CFG_RISE_AFTER_SHORT, rise_short_v);
    endtask

    // stop offering, wait for every decision to come back, then let the pipe empty
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        int stall;
        int taken;
        bit pressed;
        stall   = 0;
        taken   = 0;
        pressed = 1'b0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (result_valid && result_ready)
                taken++;
            if (stall > 0)
                stall--;
            else if (!pressed && taken == HOLD_AT) begin
                pressed = 1'b1;
                stall   = HOLD_CYCLES;
            end
            else if ($urandom_range(99, 0) < take_idle_pct)
                stall = gap_len();
            result_ready <= (stall == 0);
        end
    end

    // ends the run when no request has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        send_idle_pct = 20;
        take_idle_pct = 20;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and alternating bit patterns open the first frame
        opening = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
                    16'sh5555, 16'shAAAA, -16'sd16384, 16'sd16384};

        // reset thresholds, walk the window sequencer through every transition
        plan_whole(SEG_STEADY, 1000);
        send_frame();                           // flat frame, stays only long
        plan_whole(SEG_SPLIT, FULL_SCALE);
        send_frame();                           // burst after long, long start
        send_frame();                           // steady after start, forced short
        plan_whole(SEG_STEADY, 0);
        send_frame();                           // silence after short, long stop
        plan_whole(SEG_SPLIT, FULL_SCALE);
        send_frame();                           // burst after stop, long start
        plan_whole(SEG_STEADY, 0);
        send_frame();                           // below floor after start, still short
        plan_whole(SEG_SPLIT, FULL_SCALE);
        send_frame();                           // burst after short, stays short
        send_frame();                           // no change after short, long stop
        plan_whole(SEG_STEADY, FULL_SCALE);
        send_frame();                           // full-scale constant, zero variance
        drain();

        // zero thresholds: any change above nothing goes short, no idling at all
        send_idle_pct = 0;
        take_idle_pct = 0;
        set_thresholds('0, '0, '0);
        run_frames(6);
        drain();

        // thresholds at the top of the register: never short
        send_idle_pct = 30;
        take_idle_pct = 30;
        set_thresholds(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES);
        write_reg(CFG_SPARE_IDX, vbs_pkg::VAR_W'($urandom));
        run_frames(6);
        drain();

        // back to the reset values; the long receiver hold-off lands here,
        // the sender keeps nearly full rate so the input gets blocked
        send_idle_pct = 5;
        take_idle_pct = 10;
        set_thresholds(vbs_pkg::ENERGY_FLOOR_RST, vbs_pkg::RISE_AFTER_LONG_RST,
                       vbs_pkg::RISE_AFTER_SHORT_RST);
        run_frames(10);
        drain();

        // random thresholds in the range where decisions flip
        send_idle_pct = 20;
        take_idle_pct = 20;
        repeat (3) begin
            set_thresholds(vbs_pkg::VAR_W'($urandom_range(Q30_QUARTER / 2, 0)),
                           vbs_pkg::VAR_W'($urandom_range(Q30_QUARTER / 4, 0)),
                           vbs_pkg::VAR_W'($urandom_range(Q30_QUARTER / 4, 0)));
            run_frames(5);
            drain();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
